>>> sv/rpg_pkg.sv
// shared types, constants, microcode and symbol table for the password generator
package rpg_pkg;

   localparam int MAX_LENGTH = 64;
   localparam int COUNT_W = $clog2(MAX_LENGTH + 1);
   localparam int SEED_W = 31;
   localparam int LEN_W = 7;
   localparam int SYM_W = 8;
   localparam int PC_W = 3;
   localparam int PROD_W = 46;
   localparam int QUOT_W = 26;
   localparam int REM_W = 7;
   localparam int IDX_W = 6;
   localparam int TABLE_SIZE = 62;
   localparam int RECIP_SHIFT = 36;

   localparam logic [14:0] LCG_MUL = 15'd16807;
   localparam logic [SEED_W-1:0] MODULUS = 31'h7fffffff;
   localparam logic [SEED_W-1:0] ZERO_SUBST = 31'd123459876;
   // floor(2^36 / 62), quotient comes out exact or one low
   localparam logic [SEED_W-1:0] RECIP_62 = 31'd1108378657;

   localparam logic [8*TABLE_SIZE-1:0] SYMBOLS =
      "AaBbCcDdEeFfGgHh0Ii1Gg2Kk3Ll4Mm5Nn6Oo7Pp8Qq9RrSsTtUuVvWwXxYyZz";

   typedef struct packed {
      logic [SEED_W-1:0] seed;
      logic [LEN_W-1:0]  length;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
      logic             status;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_ERROR,
      OP_MUL,
      OP_RED,
      OP_DIV,
      OP_REM,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      C_NEVER,
      C_ALWAYS,
      C_LEN_NZ,
      C_MORE
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
      logic [PC_W-1:0] next;
   } ctl_type;

   typedef struct packed {
      logic req_valid;
      logic len_nz;
      logic more;
      logic out_busy;
   } stat_type;

   localparam logic [PC_W-1:0] PC_ACCEPT = 3'd0;
   localparam logic [PC_W-1:0] PC_ERROR = 3'd1;
   localparam logic [PC_W-1:0] PC_MUL = 3'd2;
   localparam logic [PC_W-1:0] PC_RED = 3'd3;
   localparam logic [PC_W-1:0] PC_DIV = 3'd4;
   localparam logic [PC_W-1:0] PC_REM = 3'd5;
   localparam logic [PC_W-1:0] PC_EMIT = 3'd6;

   function automatic ctl_type microcode(input logic [PC_W-1:0] pc);
      ctl_type w;
      w = '{op: OP_NOP, cond: C_ALWAYS, target: PC_ACCEPT, next: PC_ACCEPT};
      case (pc)
         PC_ACCEPT: w = '{op: OP_ACCEPT, cond: C_LEN_NZ, target: PC_MUL, next: PC_ERROR};
         PC_ERROR:  w = '{op: OP_ERROR, cond: C_NEVER, target: PC_ACCEPT, next: PC_ACCEPT};
         PC_MUL:    w = '{op: OP_MUL, cond: C_NEVER, target: PC_ACCEPT, next: PC_RED};
         PC_RED:    w = '{op: OP_RED, cond: C_NEVER, target: PC_ACCEPT, next: PC_DIV};
         PC_DIV:    w = '{op: OP_DIV, cond: C_NEVER, target: PC_ACCEPT, next: PC_REM};
         PC_REM:    w = '{op: OP_REM, cond: C_NEVER, target: PC_ACCEPT, next: PC_EMIT};
         PC_EMIT:   w = '{op: OP_EMIT, cond: C_MORE, target: PC_MUL, next: PC_ACCEPT};
         default:   w = '{op: OP_NOP, cond: C_ALWAYS, target: PC_ACCEPT, next: PC_ACCEPT};
      endcase
      return w;
   endfunction

   function automatic logic [SYM_W-1:0] symbol_of(input logic [IDX_W-1:0] idx);
      logic [8*TABLE_SIZE-1:0] shifted;
      shifted = SYMBOLS >> (SYM_W * (TABLE_SIZE - 1 - int'(idx)));
      return shifted[SYM_W-1:0];
   endfunction

endpackage

>>> sv/rpg_seq.sv
// microcode sequencer: step counter, control store and branch logic
module rpg_seq (
   input  logic              clock,
   input  logic              reset,
   input  rpg_pkg::stat_type stat,
   output rpg_pkg::ctl_type  ctl
);

   logic [rpg_pkg::PC_W-1:0] pc_ff, pc_in;
   logic hold;
   logic taken;

   assign ctl = rpg_pkg::microcode(pc_ff);

   always_comb begin
      hold = 1'b0;
      case (ctl.op)
         rpg_pkg::OP_ACCEPT: hold = !stat.req_valid;
         rpg_pkg::OP_ERROR,
         rpg_pkg::OP_EMIT:   hold = stat.out_busy;
         default:            hold = 1'b0;
      endcase
   end

   always_comb begin
      taken = 1'b0;
      case (ctl.cond)
         rpg_pkg::C_NEVER:  taken = 1'b0;
         rpg_pkg::C_ALWAYS: taken = 1'b1;
         rpg_pkg::C_LEN_NZ: taken = stat.len_nz;
         rpg_pkg::C_MORE:   taken = stat.more;
         default:           taken = 1'b0;
      endcase
   end

   always_comb begin
      if (hold) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = ctl.target;
      end else begin
         pc_in = ctl.next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= rpg_pkg::PC_ACCEPT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> sv/rpg_dp.sv
// datapath: generator register, multiplier, modular fold, mod-62 and output word
module rpg_dp (
   input  logic              clock,
   input  logic              reset,
   input  rpg_pkg::ctl_type  ctl,
   output rpg_pkg::stat_type stat,
   input  logic              req_valid,
   output logic              req_stall,
   input  rpg_pkg::req_type  req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rpg_pkg::rsp_type  rsp_word
);

   logic [rpg_pkg::SEED_W-1:0]  gen_ff, gen_in;
   logic [rpg_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [rpg_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [rpg_pkg::QUOT_W-1:0]  quot_ff, quot_in;
   logic [rpg_pkg::REM_W-1:0]   rem_ff, rem_in;
   rpg_pkg::rsp_type            rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        out_busy;
   logic                        len_nz;
   logic [rpg_pkg::SEED_W-1:0]  gen_eff;
   logic [rpg_pkg::SEED_W:0]    fold;
   logic [rpg_pkg::SEED_W:0]    fold_red;
   logic [61:0]                 recip_prod;
   logic [rpg_pkg::SEED_W:0]    quot_x62;
   logic [rpg_pkg::SEED_W:0]    diff;
   logic [rpg_pkg::IDX_W-1:0]   idx;
   logic [rpg_pkg::COUNT_W-1:0] len_sat;

   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign len_nz    = req_word.length != '0;
   assign req_stall = ctl.op != rpg_pkg::OP_ACCEPT;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign stat.req_valid = req_valid;
   assign stat.len_nz    = len_nz;
   assign stat.more      = count_ff != rpg_pkg::COUNT_W'(1);
   assign stat.out_busy  = out_busy;

   // zero would be a fixed point of the generator
   assign gen_eff = (gen_ff == '0) ? rpg_pkg::ZERO_SUBST : gen_ff;

   // 2^31 = 1 mod (2^31-1): fold high part onto low part
   assign fold     = {1'b0, prod_ff[rpg_pkg::SEED_W-1:0]}
                   + (rpg_pkg::SEED_W+1)'(prod_ff[rpg_pkg::PROD_W-1:rpg_pkg::SEED_W]);
   assign fold_red = (fold >= {1'b0, rpg_pkg::MODULUS}) ? fold - {1'b0, rpg_pkg::MODULUS}
                                                         : fold;

   assign recip_prod = 62'(gen_ff) * 62'(rpg_pkg::RECIP_62);

   // 62*q as 64*q - 2*q
   assign quot_x62 = ((rpg_pkg::SEED_W+1)'(quot_ff) << 6) - ((rpg_pkg::SEED_W+1)'(quot_ff) << 1);
   assign diff     = {1'b0, gen_ff} - quot_x62;

   assign idx = (rem_ff >= rpg_pkg::REM_W'(rpg_pkg::TABLE_SIZE))
              ? rpg_pkg::IDX_W'(rem_ff - rpg_pkg::REM_W'(rpg_pkg::TABLE_SIZE))
              : rpg_pkg::IDX_W'(rem_ff);

   assign len_sat = (req_word.length > rpg_pkg::LEN_W'(rpg_pkg::MAX_LENGTH))
                  ? rpg_pkg::COUNT_W'(rpg_pkg::MAX_LENGTH)
                  : rpg_pkg::COUNT_W'(req_word.length);

   always_comb begin
      gen_in       = gen_ff;
      count_in     = count_ff;
      prod_in      = prod_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (ctl.op)
         rpg_pkg::OP_ACCEPT: begin
            if (req_valid && len_nz) begin
               gen_in   = req_word.seed;
               count_in = len_sat;
            end
         end
         rpg_pkg::OP_ERROR: begin
            if (!out_busy) begin
               rsp_in       = '{symbol: '0, last: 1'b1, status: 1'b1};
               rsp_valid_in = 1'b1;
            end
         end
         rpg_pkg::OP_MUL: begin
            prod_in = rpg_pkg::PROD_W'(gen_eff) * rpg_pkg::PROD_W'(rpg_pkg::LCG_MUL);
         end
         rpg_pkg::OP_RED: begin
            gen_in = fold_red[rpg_pkg::SEED_W-1:0];
         end
         rpg_pkg::OP_DIV: begin
            quot_in = recip_prod[rpg_pkg::RECIP_SHIFT +: rpg_pkg::QUOT_W];
         end
         rpg_pkg::OP_REM: begin
            // remainder stays below 124 since the quotient is at most one low
            rem_in = diff[rpg_pkg::REM_W-1:0];
         end
         rpg_pkg::OP_EMIT: begin
            if (!out_busy) begin
               rsp_in       = '{symbol: rpg_pkg::symbol_of(idx),
                                last: count_ff == rpg_pkg::COUNT_W'(1),
                                status: 1'b0};
               rsp_valid_in = 1'b1;
               count_in     = count_ff - rpg_pkg::COUNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff       <= rpg_pkg::SEED_W'(1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gen_ff       <= gen_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff <= prod_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

endmodule

>>> sv/random_password_generator.sv
// Password generator: a request word carries a 31-bit seed and a length; the block
// loads the seed into a minimal standard Lehmer generator (x * 16807 mod 2^31-1,
// zero replaced by 123459876) and returns one character word per step, the generator
// value mod 62 picking a byte of the fixed symbol table, with last set on the final
// one. Lengths above 64 give 64 characters; a length of zero gives a single word with
// status 1, last 1 and symbol 0, and leaves the generator untouched. A request runs
// a microcoded loop of multiply, fold, reciprocal divide, remainder and emit per
// character; words wait while the result side is stalled. The next request is taken
// once the last character word is registered.
module random_password_generator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rpg_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rpg_pkg::rsp_type rsp_word
);

   rpg_pkg::ctl_type  ctl;
   rpg_pkg::stat_type stat;

   rpg_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   rpg_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .stat      (stat),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

>>> sv/rpg_checker.sv
// port-level checks for the password generator, bound to the top level
module rpg_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rpg_pkg::rsp_type rsp_word
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   a_error_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status |-> rsp_word.last && rsp_word.symbol == '0)
      else $error("error word malformed");

   a_ok_symbol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.status |-> rsp_word.symbol != '0)
      else $error("success word carries empty symbol");

endmodule

bind random_password_generator rpg_checker u_rpg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

>>> bench/rpg_char_checker.sv
// checker for the password generator: predicts every character word and compares
`timescale 1ns / 100ps

module rpg_char_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  rpg_pkg::req_type req_word,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rpg_pkg::rsp_type rsp_word,
   output int               outstanding,
   output int               failures
);

   localparam int     CHAR_LIMIT = 64;
   localparam int     TABLE_LEN = 62;
   localparam longint LEHMER_MUL = 16807;
   localparam longint SCHRAGE_Q = 127773;
   localparam longint SCHRAGE_R = 2836;
   localparam longint LEHMER_MOD = 64'h7fff_ffff;
   localparam longint ZERO_SEED = 123459876;

   // symbol table as given, second Gg pair included
   localparam logic [8*TABLE_LEN-1:0] CHARSET =
      "AaBbCcDdEeFfGgHh0Ii1Gg2Kk3Ll4Mm5Nn6Oo7Pp8Qq9RrSsTtUuVvWwXxYyZz";

   rpg_pkg::rsp_type          pending_chars[$];
   logic [rpg_pkg::SEED_W-1:0] lehmer_state = 31'd1;

   // one multiply-mod step, Schrage split so nothing overflows
   function automatic logic [rpg_pkg::SEED_W-1:0] lehmer_step(
      input logic [rpg_pkg::SEED_W-1:0] v);
      longint cur, hi, lo, x;
      cur = (v == '0) ? ZERO_SEED : longint'(v);
      hi = cur / SCHRAGE_Q;
      lo = cur % SCHRAGE_Q;
      x = LEHMER_MUL * lo - SCHRAGE_R * hi;
      if (x < 0) begin
         x = x + LEHMER_MOD;
      end
      return x[rpg_pkg::SEED_W-1:0];
   endfunction

   task automatic predict_password(input rpg_pkg::req_type w);
      rpg_pkg::rsp_type c;
      int               n;
      int               idx;
      if (w.length == '0) begin
         // zero length: one error word, generator left alone
         c.symbol = '0;
         c.last = 1'b1;
         c.status = 1'b1;
         pending_chars.push_back(c);
      end else begin
         n = (int'(w.length) > CHAR_LIMIT) ? CHAR_LIMIT : int'(w.length);
         lehmer_state = w.seed;
         for (int i = n; i > 0; i--) begin
            lehmer_state = lehmer_step(lehmer_state);
            idx = lehmer_state % TABLE_LEN;
            c.symbol = CHARSET[8*(TABLE_LEN-1-idx) +: 8];
            c.last = (i == 1);
            c.status = 1'b0;
            pending_chars.push_back(c);
         end
      end
   endtask

   task automatic report_bad_char(input string what, input int got, input int want);
      $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
      failures = failures + 1;
   endtask

   always @(posedge clock) begin
      rpg_pkg::rsp_type want;
      if (reset) begin
         pending_chars.delete();
         lehmer_state = 31'd1;
      end else begin
         // compare before predicting, a word cannot answer a request of the same edge
         if (rsp_valid && !rsp_stall) begin
            if (pending_chars.size() == 0) begin
               report_bad_char("word with nothing expected", int'(rsp_word), 0);
            end else begin
               want = pending_chars.pop_front();
               if (rsp_word.symbol !== want.symbol) begin
                  report_bad_char("symbol", rsp_word.symbol, want.symbol);
               end
               if (rsp_word.last !== want.last) begin
                  report_bad_char("last", rsp_word.last, want.last);
               end
               if (rsp_word.status !== want.status) begin
                  report_bad_char("status", rsp_word.status, want.status);
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_password(req_word);
         end
      end
      outstanding = pending_chars.size();
   end

endmodule

>>> bench/random_password_generator_tb.sv
// top of the password generator bench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module random_password_generator_tb;

   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   rpg_pkg::req_type req_word = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rpg_pkg::rsp_type rsp_word;

   int outstanding;
   int failures;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   random_password_generator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   rpg_char_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .outstanding (outstanding),
      .failures    (failures)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99, 0) < recv_stall_pct);
   end

   // ends the run when neither side moves a word for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // mostly short passwords, some saturated, some zero length and odd seeds
   function automatic rpg_pkg::req_type random_request();
      rpg_pkg::req_type w;
      logic [31:0]      raw;
      int               pick;
      raw = $urandom();
      w.seed = raw[rpg_pkg::SEED_W-1:0];
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
         w.seed = '0;
      end else if (pick < 12) begin
         w.seed = '1;
      end else if (pick < 20) begin
         w.seed = rpg_pkg::SEED_W'($urandom_range(200000, 1));
      end
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
         w.length = '0;
      end else if (pick < 16) begin
         w.length = rpg_pkg::LEN_W'($urandom_range(127, 65));
      end else if (pick < 24) begin
         w.length = 7'd64;
      end else if (pick < 36) begin
         w.length = rpg_pkg::LEN_W'($urandom_range(63, 17));
      end else begin
         w.length = rpg_pkg::LEN_W'($urandom_range(16, 1));
      end
      return w;
   endfunction

   // called and returning at a falling edge, valid stays high on return
   task automatic send_request(input logic [rpg_pkg::SEED_W-1:0] seed,
                               input logic [rpg_pkg::LEN_W-1:0] count);
      rpg_pkg::req_type w;
      w.seed = seed;
      w.length = count;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_word <= random_request();
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // hold the sender off until every character word is back
   task automatic drain_passwords();
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (outstanding != 0);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int count);
      rpg_pkg::req_type w;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         w = random_request();
         send_request(w.seed, w.length);
      end
      drain_passwords();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero seed, and the all-ones seed that steps to zero
      send_request(31'd0, 7'd1);
      send_request(31'h7fff_ffff, 7'd4);
      send_request(31'd1, 7'd64);
      send_request(31'h7fff_fffe, 7'd2);
      // zero length words, back to back
      send_request(31'd12345, 7'd0);
      send_request(31'h7fff_ffff, 7'd0);
      send_request(31'd0, 7'd0);
      // lengths past the limit saturate, followed by one within it
      send_request(31'd42, 7'd65);
      send_request(31'h5555_5555, 7'd127);
      send_request(31'h2aaa_aaaa, 7'd42);
      // around the Schrage split points
      send_request(31'd127773, 7'd3);
      send_request(31'd127772, 7'd3);
      send_request(31'd16807, 7'd5);
      send_request(31'd123459876, 7'd2);
      send_request(31'd1, 7'd1);
      send_request(31'd0, 7'd64);
      drain_passwords();

      run_phase(0, 0, 66);
      run_phase(56, 0, 66);
      run_phase(0, 56, 66);
      run_phase(30, 30, 66);

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/rpg_pkg.sv
sv/rpg_seq.sv
sv/rpg_dp.sv
sv/random_password_generator.sv
sv/rpg_checker.sv
bench/rpg_char_checker.sv
bench/random_password_generator_tb.sv
